@@ hw/rtl/sic_pkg.sv @@
// ----------------------------------------------------------------------------
// sic_pkg
// Shared widths, pipeline types and the restoring division step used by the
// segment intersection core.
// ----------------------------------------------------------------------------
`default_nettype none

package sic_pkg;

  localparam int CW  = 16;           // coordinate bits
  localparam int FB  = 16;           // fraction bits of results
  localparam int OW  = 32;           // result coordinate bits
  localparam int EW  = 64;           // working width of the final point math
  localparam int DW  = CW + 1;       // coordinate difference
  localparam int PW  = 2 * DW;       // product of two differences
  localparam int XW  = PW + 1;       // cross product
  localparam int MW  = DW + XW;      // |difference| * |cross|
  localparam int NW  = MW + FB;      // scaled dividend
  localparam int QB  = CW + FB + 2;  // quotient bits kept; larger is a miss
  localparam int HW  = NW - QB;      // dividend bits above the quotient window

  typedef logic signed [CW-1:0] coord_t;

  typedef struct packed {
    coord_t ax, ay, bx, by, cx, cy, dx, dy;
    coord_t lx, ly, hx, hy;
    logic   box_ok;
    logic   par;
    logic   col;
    logic   neg_x;
    logic   neg_y;
  } side_t;

  typedef struct packed {
    logic [XW-1:0] rem;
    logic [QB-1:0] low;
    logic [QB-1:0] quo;
    logic          ovf;
  } div_t;

  typedef struct packed {
    logic          vld;
    logic [XW-1:0] dmag;
    div_t          qx;
    div_t          qy;
    side_t         side;
  } cell_t;

  // One restoring division step: shift in the next dividend bit, subtract.
  function automatic div_t div_step(div_t s, logic [XW-1:0] dmag);
    logic [XW:0] t;
    div_t        r;
    r     = s;
    t     = {s.rem, s.low[QB-1]};
    r.low = {s.low[QB-2:0], 1'b0};
    if (t >= {1'b0, dmag}) begin
      t     = t - {1'b0, dmag};
      r.quo = {s.quo[QB-2:0], 1'b1};
    end else begin
      r.quo = {s.quo[QB-2:0], 1'b0};
    end
    r.rem = t[XW-1:0];
    return r;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/sic_div_cell.sv @@
// ----------------------------------------------------------------------------
// sic_div_cell
// One cell of the division chain: one quotient bit for each axis, side data
// handed on unchanged.
// ----------------------------------------------------------------------------
`default_nettype none

module sic_div_cell
  import sic_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  adv,
  input  wire cell_t cell_i,
  output cell_t      cell_o
);

  cell_t cell_r;
  cell_t cell_nxt;

  always_comb begin
    cell_nxt    = cell_i;
    cell_nxt.qx = div_step(cell_i.qx, cell_i.dmag);
    cell_nxt.qy = div_step(cell_i.qy, cell_i.dmag);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.vld <= 1'b0;
    end else if (adv) begin
      cell_r <= cell_nxt;
    end
  end

  assign cell_o = cell_r;

endmodule

`default_nettype wire

@@ hw/rtl/segment_intersection_core.sv @@
// ----------------------------------------------------------------------------
// segment_intersection_core
// Exact integer segment intersection test; a pair per cycle unless stalled.
// ----------------------------------------------------------------------------
// Takes one segment pair per clock unless the output stalls and returns hit
// plus the crossing point (or the collinear overlap) in floored Q16.16; all
// result fields are zero on a miss. The pipeline streams one transfer per
// cycle in and out unless stalled, through 5 front-end stages, QB (34)
// division cells and 1 output register; the depth comes from the restoring
// divider, a chain of cells producing one quotient bit per stage for both
// axes. When the output register holds an untaken result, the pipeline still
// advances while its last stage is empty; otherwise the whole chain holds.
// ----------------------------------------------------------------------------
`default_nettype none

module segment_intersection_core
  import sic_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic signed [CW-1:0] in_first_start_x,
  input  wire logic signed [CW-1:0] in_first_start_y,
  input  wire logic signed [CW-1:0] in_first_end_x,
  input  wire logic signed [CW-1:0] in_first_end_y,
  input  wire logic signed [CW-1:0] in_second_start_x,
  input  wire logic signed [CW-1:0] in_second_start_y,
  input  wire logic signed [CW-1:0] in_second_end_x,
  input  wire logic signed [CW-1:0] in_second_end_y,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic                      out_hit,
  output logic signed [OW-1:0]      out_left_x,
  output logic signed [OW-1:0]      out_left_y,
  output logic signed [OW-1:0]      out_right_x,
  output logic signed [OW-1:0]      out_right_y
);

  function automatic logic lex_less(coord_t ax, coord_t ay, coord_t bx, coord_t by);
    return (ax < bx) || ((ax == bx) && (ay < by));
  endfunction

  function automatic logic ranges_meet(coord_t a, coord_t b, coord_t c, coord_t d);
    coord_t lo1, hi1, lo2, hi2, lo, hi;
    lo1 = (a < b) ? a : b;
    hi1 = (a < b) ? b : a;
    lo2 = (c < d) ? c : d;
    hi2 = (c < d) ? d : c;
    lo  = (lo1 > lo2) ? lo1 : lo2;
    hi  = (hi1 < hi2) ? hi1 : hi2;
    return lo <= hi;
  endfunction

  // Inclusive box test at fixed-point scale.
  function automatic logic inside_box(coord_t a, coord_t b, logic signed [EW-1:0] p);
    logic signed [EW-1:0] lo, hi;
    lo = EW'($signed((a < b) ? a : b)) <<< FB;
    hi = EW'($signed((a < b) ? b : a)) <<< FB;
    return (lo <= p) && (p <= hi);
  endfunction

  function automatic logic [OW-1:0] scale_out(coord_t c);
    logic signed [EW-1:0] w;
    w = EW'($signed(c)) <<< FB;
    return w[OW-1:0];
  endfunction

  // Floored signed quotient plus base coordinate, in the working width.
  function automatic logic signed [EW-1:0] point(coord_t base, div_t q, logic neg);
    logic signed [EW-1:0] mag, qs;
    mag = EW'({1'b0, q.quo});
    if (neg) begin
      qs = -(mag + EW'(q.rem != '0));
    end else begin
      qs = mag;
    end
    return (EW'($signed(base)) <<< FB) + qs;
  endfunction

  logic adv;
  cell_t chain [QB+1];

  // Advance unless a result is waiting and the last cell holds another one.
  assign adv      = !chain[QB].vld || !out_valid || out_ready;
  assign in_ready = adv;

  // Stage 1: capture the pair.
  logic  v1_r;
  side_t s1_r, s1_nxt;

  always_comb begin
    s1_nxt    = '0;
    s1_nxt.ax = in_first_start_x;
    s1_nxt.ay = in_first_start_y;
    s1_nxt.bx = in_first_end_x;
    s1_nxt.by = in_first_end_y;
    s1_nxt.cx = in_second_start_x;
    s1_nxt.cy = in_second_start_y;
    s1_nxt.dx = in_second_end_x;
    s1_nxt.dy = in_second_end_y;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r <= s1_nxt;
    end
  end

  // Stage 2: differences, box overlap, ordered collinear overlap ends.
  logic                 v2_r;
  side_t                s2_r, s2_nxt;
  logic signed [DW-1:0] rx_r, ry_r, sx_r, sy_r, wx_r, wy_r;

  always_comb begin
    coord_t p0x, p0y, p1x, p1y, q0x, q0y, q1x, q1y;
    s2_nxt        = s1_r;
    s2_nxt.box_ok = ranges_meet(s1_r.ax, s1_r.bx, s1_r.cx, s1_r.dx) &&
                    ranges_meet(s1_r.ay, s1_r.by, s1_r.cy, s1_r.dy);
    if (lex_less(s1_r.bx, s1_r.by, s1_r.ax, s1_r.ay)) begin
      p0x = s1_r.bx; p0y = s1_r.by; p1x = s1_r.ax; p1y = s1_r.ay;
    end else begin
      p0x = s1_r.ax; p0y = s1_r.ay; p1x = s1_r.bx; p1y = s1_r.by;
    end
    if (lex_less(s1_r.dx, s1_r.dy, s1_r.cx, s1_r.cy)) begin
      q0x = s1_r.dx; q0y = s1_r.dy; q1x = s1_r.cx; q1y = s1_r.cy;
    end else begin
      q0x = s1_r.cx; q0y = s1_r.cy; q1x = s1_r.dx; q1y = s1_r.dy;
    end
    if (lex_less(p0x, p0y, q0x, q0y)) begin
      s2_nxt.lx = q0x; s2_nxt.ly = q0y;
    end else begin
      s2_nxt.lx = p0x; s2_nxt.ly = p0y;
    end
    if (lex_less(q1x, q1y, p1x, p1y)) begin
      s2_nxt.hx = q1x; s2_nxt.hy = q1y;
    end else begin
      s2_nxt.hx = p1x; s2_nxt.hy = p1y;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_r <= s2_nxt;
      rx_r <= DW'(s1_r.bx) - DW'(s1_r.ax);
      ry_r <= DW'(s1_r.by) - DW'(s1_r.ay);
      sx_r <= DW'(s1_r.dx) - DW'(s1_r.cx);
      sy_r <= DW'(s1_r.dy) - DW'(s1_r.cy);
      wx_r <= DW'(s1_r.cx) - DW'(s1_r.ax);
      wy_r <= DW'(s1_r.cy) - DW'(s1_r.ay);
    end
  end

  // Stage 3: cross product terms.
  logic                 v3_r;
  side_t                s3_r;
  logic signed [DW-1:0] rx3_r, ry3_r;
  logic signed [PW-1:0] p_rs_r, p_sr_r, p_ws_r, p_sw_r, p_c1_r, p_c2_r, p_c3_r, p_c4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (adv) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_r   <= s2_r;
      rx3_r  <= rx_r;
      ry3_r  <= ry_r;
      p_rs_r <= rx_r * sy_r;
      p_sr_r <= ry_r * sx_r;
      p_ws_r <= wx_r * sy_r;
      p_sw_r <= wy_r * sx_r;
      p_c1_r <= rx_r * wy_r;
      p_c2_r <= ry_r * wx_r;
      p_c3_r <= sx_r * wy_r;
      p_c4_r <= sy_r * wx_r;
    end
  end

  // Stage 4: denominator, numerator, parallel and collinear flags.
  logic                 v4_r;
  side_t                s4_r, s4_nxt;
  logic signed [DW-1:0] rx4_r, ry4_r;
  logic signed [XW-1:0] den_nxt, num_nxt, den_r, num_r;

  always_comb begin
    logic signed [XW-1:0] c1, c2;
    den_nxt      = XW'(p_rs_r) - XW'(p_sr_r);
    num_nxt      = XW'(p_ws_r) - XW'(p_sw_r);
    c1           = XW'(p_c1_r) - XW'(p_c2_r);
    c2           = XW'(p_c3_r) - XW'(p_c4_r);
    s4_nxt       = s3_r;
    s4_nxt.par   = (den_nxt == '0);
    s4_nxt.col   = (c1 == '0) && (c2 == '0);
    s4_nxt.neg_x = (rx3_r[DW-1] ^ num_nxt[XW-1]) ^ den_nxt[XW-1];
    s4_nxt.neg_y = (ry3_r[DW-1] ^ num_nxt[XW-1]) ^ den_nxt[XW-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (adv) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_r  <= s4_nxt;
      rx4_r <= rx3_r;
      ry4_r <= ry3_r;
      den_r <= den_nxt;
      num_r <= num_nxt;
    end
  end

  // Stage 5: magnitudes of the dividends and the divisor.
  logic          v5_r;
  side_t         s5_r;
  logic [MW-1:0] mx_r, my_r;
  logic [XW-1:0] dmag_r;
  logic [DW-1:0] rxm, rym;
  logic [XW-1:0] nm, dm;

  assign rxm = rx4_r[DW-1] ? DW'(-rx4_r) : DW'(rx4_r);
  assign rym = ry4_r[DW-1] ? DW'(-ry4_r) : DW'(ry4_r);
  assign nm  = num_r[XW-1] ? XW'(-num_r) : XW'(num_r);
  assign dm  = den_r[XW-1] ? XW'(-den_r) : XW'(den_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (adv) begin
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_r   <= s4_r;
      mx_r   <= MW'(rxm) * MW'(nm);
      my_r   <= MW'(rym) * MW'(nm);
      dmag_r <= dm;
    end
  end

  // Divider setup: quotients wider than QB bits are flagged as a miss.
  function automatic div_t div_init(logic [MW-1:0] m, logic [XW-1:0] d);
    logic [NW-1:0]    n;
    logic [HW+XW-1:0] hi_ext;
    div_t             r;
    n      = NW'(m) << FB;
    hi_ext = (HW+XW)'(n[NW-1:QB]);
    r.ovf  = (hi_ext >= (HW+XW)'(d));
    r.rem  = hi_ext[XW-1:0];
    r.low  = n[QB-1:0];
    r.quo  = '0;
    return r;
  endfunction

  always_comb begin
    chain[0].vld  = v5_r;
    chain[0].dmag = dmag_r;
    chain[0].qx   = div_init(mx_r, dmag_r);
    chain[0].qy   = div_init(my_r, dmag_r);
    chain[0].side = s5_r;
  end

  for (genvar g = 0; g < QB; g++) begin : g_cell
    sic_div_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .adv    (adv),
      .cell_i (chain[g]),
      .cell_o (chain[g+1])
    );
  end

  // Final: point, box tests, selection, output register.
  logic                 out_valid_r, hit_r, hit_nxt;
  logic [OW-1:0]        lx_r, ly_r, hx_r, hy_r, lx_nxt, ly_nxt, hx_nxt, hy_nxt;
  logic signed [EW-1:0] px, py;
  side_t                sf;

  assign sf = chain[QB].side;
  assign px = point(sf.ax, chain[QB].qx, sf.neg_x);
  assign py = point(sf.ay, chain[QB].qy, sf.neg_y);

  always_comb begin
    lx_nxt = '0;
    ly_nxt = '0;
    hx_nxt = '0;
    hy_nxt = '0;
    hit_nxt = 1'b0;
    if (sf.box_ok) begin
      if (sf.par) begin
        if (sf.col) begin
          hit_nxt = 1'b1;
          lx_nxt  = scale_out(sf.lx);
          ly_nxt  = scale_out(sf.ly);
          hx_nxt  = scale_out(sf.hx);
          hy_nxt  = scale_out(sf.hy);
        end
      end else if (!chain[QB].qx.ovf && !chain[QB].qy.ovf &&
                   inside_box(sf.ax, sf.bx, px) && inside_box(sf.ay, sf.by, py) &&
                   inside_box(sf.cx, sf.dx, px) && inside_box(sf.cy, sf.dy, py)) begin
        hit_nxt = 1'b1;
        lx_nxt  = px[OW-1:0];
        ly_nxt  = py[OW-1:0];
        hx_nxt  = px[OW-1:0];
        hy_nxt  = py[OW-1:0];
      end
    end
  end

  // Keep an untaken result valid while an empty last cell lets the chain move.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= chain[QB].vld || (out_valid_r && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (adv && chain[QB].vld) begin
      hit_r <= hit_nxt;
      lx_r  <= lx_nxt;
      ly_r  <= ly_nxt;
      hx_r  <= hx_nxt;
      hy_r  <= hy_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_hit     = hit_r;
  assign out_left_x  = lx_r;
  assign out_left_y  = ly_r;
  assign out_right_x = hx_r;
  assign out_right_y = hy_r;

`ifndef ASSERT_OFF
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_hit) |->
      (out_left_x == '0 && out_left_y == '0 && out_right_x == '0 && out_right_y == '0))
    else $error("miss result carries nonzero coordinates");

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> v1_r)
    else $error("accepted transfer did not enter the pipeline");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");
`endif

endmodule

`default_nettype wire
